// ----- src/smm_pkg.sv -----
package smm_pkg;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned SIZE_W = 7;
	localparam int unsigned DATA_W = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] OP_QUERY      = 2'd2;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [DATA_W-1:0] element_value;
	} smm_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic signed [DATA_W-1:0] product_value;
	} smm_out_t;

	typedef struct packed {
		logic              wr_left;
		logic              wr_right;
		logic              start;
		logic              issue;
		logic              out_load;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [SIZE_W-1:0] k;
	} smm_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} smm_sts_t;

endpackage

// ----- src/square_matrix_multiply.sv -----
// channel   direction  handshake              payload
// req       in         req_valid / req_stall   smm_in_t  (load left, load right, query)
// rsp       out        rsp_valid / rsp_stall   smm_out_t (one per query)
// cfg       in         cfg_we                  cfg_wdata (matrix_size)
//
// a load leaves the block idle; the next request is taken in the following cycle
// a query inside the matrix walks n terms (n = effective size) through the one read
// port of each matrix store, one term per cycle, then drains the read, multiply and
// accumulate stages; a query outside the matrix skips the walk and goes to S_FINISH
// reset clears control and sets matrix_size to 64; the stores are undefined until written
// a stalled response holds in rsp_q; loads go on, the next query waits in S_FINISH

module square_matrix_multiply import smm_pkg::*; #(
	parameter int unsigned MAX_DIM = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  smm_in_t           req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output smm_out_t          rsp,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	smm_cmd_t cmd;
	smm_sts_t sts;

	smm_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.cmd       (cmd)
	);

	smm_datapath #(
		.MAX_DIM(MAX_DIM)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	a_issue_fills_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> sts.pipe_busy)
		else $error("read issued but pipeline shows no valid stage");

	a_start_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.pipe_busy)
		else $error("query started with terms still in flight");

	a_load_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!sts.pipe_busy && !cmd.issue))
		else $error("result loaded before accumulation finished");

	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> req_stall)
		else $error("request transfer possible right after a query");

	a_write_not_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_left || cmd.wr_right) |-> !cmd.issue)
		else $error("matrix store written during a query walk");

endmodule

// ----- src/smm_datapath.sv -----
module smm_datapath import smm_pkg::*; #(
	parameter int unsigned MAX_DIM = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  smm_in_t  req,
	input  smm_cmd_t cmd,
	output smm_sts_t sts,
	output smm_out_t rsp
);

	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] left_mem  [DEPTH];
	logic [DATA_W-1:0] right_mem [DEPTH];

	logic              wr_in_range;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr_l;
	logic [ADDR_W-1:0] rd_addr_r;
	logic [DATA_W-1:0] mul;

	logic [DATA_W-1:0] left_s1;
	logic [DATA_W-1:0] right_s1;
	logic              vld_s1;
	logic [DATA_W-1:0] prod_s2;
	logic              vld_s2;
	logic [DATA_W-1:0] acc_q;
	smm_out_t          rsp_q;

	assign wr_in_range = (32'(req.row_index) < MAX_DIM) && (32'(req.col_index) < MAX_DIM);
	assign wr_addr   = ADDR_W'(32'(req.row_index) * MAX_DIM + 32'(req.col_index));
	assign rd_addr_l = ADDR_W'(32'(cmd.row) * MAX_DIM + 32'(cmd.k));
	assign rd_addr_r = ADDR_W'(32'(cmd.k) * MAX_DIM + 32'(cmd.col));
	assign mul       = left_s1 * right_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_left && wr_in_range) begin
			left_mem[wr_addr] <= req.element_value;
		end
		if (cmd.wr_right && wr_in_range) begin
			right_mem[wr_addr] <= req.element_value;
		end
		left_s1  <= left_mem[rd_addr_l];
		right_s1 <= right_mem[rd_addr_r];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + prod_s2;
		end
		if (cmd.out_load) begin
			rsp_q.out_row       <= cmd.row;
			rsp_q.out_col       <= cmd.col;
			rsp_q.product_value <= acc_q;
		end
	end

	assign sts.pipe_busy = vld_s1 | vld_s2;
	assign rsp = rsp_q;

endmodule

// ----- src/smm_ctrl.sv -----
module smm_ctrl import smm_pkg::*; #(
	parameter int unsigned MAX_DIM = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  smm_in_t           req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  smm_sts_t          sts,
	output smm_cmd_t          cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_q;
	logic [SIZE_W-1:0] k_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              query;
	logic [SIZE_W-1:0] n_eff;
	logic              in_range;
	logic              out_load;

	assign accept   = req_valid && !req_stall;
	assign query    = accept && (req.opcode == OP_QUERY);
	assign n_eff    = (32'(size_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_q;
	assign in_range = (SIZE_W'(req.row_index) < n_eff) && (SIZE_W'(req.col_index) < n_eff);
	assign out_load = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= SIZE_RESET;
			n_q         <= '0;
			k_q         <= '0;
			row_q       <= '0;
			col_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (query) begin
						row_q <= req.row_index;
						col_q <= req.col_index;
						n_q   <= n_eff;
						k_q   <= '0;
						state_q <= in_range ? S_RUN : S_FINISH;
					end
				end
				S_RUN: begin
					k_q <= k_q + SIZE_W'(1);
					if (k_q == n_q - SIZE_W'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!sts.pipe_busy) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall    = (state_q != S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign cmd.wr_left  = accept && (req.opcode == OP_LOAD_LEFT);
	assign cmd.wr_right = accept && (req.opcode == OP_LOAD_RIGHT);
	assign cmd.start    = query;
	assign cmd.issue    = (state_q == S_RUN);
	assign cmd.out_load = out_load;
	assign cmd.row      = row_q;
	assign cmd.col      = col_q;
	assign cmd.k        = k_q;

endmodule
